### hw/rtl/qpm_pkg.sv
package qpm_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS = 14;
   localparam int COMP_W    = 16;
   localparam int POS_W     = 32;
   localparam int ENT_W     = 16;

   // internal widths: product, squared norm, numerator, quotient, dividend, result
   localparam int PROD_W = 2 * COMP_W;
   localparam int NORM_W = PROD_W + 1;
   localparam int NUM_W  = PROD_W + 2;
   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int DVD_W  = NORM_W + FRAC_BITS;
   localparam int RES_W  = (QUO_W + 1 > ENT_W) ? QUO_W + 1 : ENT_W;

   // rotation entry lanes, row major
   localparam int NUM_ENT = 9;
   localparam int E00 = 0;
   localparam int E01 = 1;
   localparam int E02 = 2;
   localparam int E10 = 3;
   localparam int E11 = 4;
   localparam int E12 = 5;
   localparam int E20 = 6;
   localparam int E21 = 7;
   localparam int E22 = 8;

   localparam logic [QUO_W-1:0] Q_ONE   = QUO_W'(1) << FRAC_BITS;
   localparam logic [RES_W-1:0] RES_ONE = RES_W'(1) << FRAC_BITS;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [ENT_W-1:0]  ent_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [NUM_W-1:0]  num_type;
   typedef logic [NORM_W-1:0]        norm_type;
   typedef logic [QUO_W-1:0]         quo_type;

   typedef struct packed {
      comp_type quat_x;
      comp_type quat_y;
      comp_type quat_z;
      comp_type quat_w;
      pos_type  pos_x;
      pos_type  pos_y;
      pos_type  pos_z;
   } quat_req_type;

   typedef struct packed {
      ent_type m00;
      ent_type m01;
      ent_type m02;
      pos_type m03;
      ent_type m10;
      ent_type m11;
      ent_type m12;
      pos_type m13;
      ent_type m20;
      ent_type m21;
      ent_type m22;
      pos_type m23;
   } pose_rsp_type;

   typedef struct packed {
      pos_type x;
      pos_type y;
      pos_type z;
   } pos3_type;

   typedef struct packed {
      prod_type xx;
      prod_type yy;
      prod_type zz;
      prod_type ww;
      prod_type xy;
      prod_type xz;
      prod_type yz;
      prod_type xw;
      prod_type yw;
      prod_type zw;
      pos3_type pos;
   } prod_stage_type;

   typedef struct packed {
      norm_type                norm;
      num_type [NUM_ENT-1:0]   num;
      pos3_type                pos;
   } sum_stage_type;

   typedef struct packed {
      norm_type                norm;
      logic                    zero;
      logic [NUM_ENT-1:0]      neg;
      norm_type [NUM_ENT-1:0]  mag;
      pos3_type                pos;
   } mag_stage_type;

   typedef struct packed {
      norm_type                norm;
      logic                    zero;
      logic [NUM_ENT-1:0]      neg;
      norm_type [NUM_ENT-1:0]  rem;
      quo_type [NUM_ENT-1:0]   acc;
      pos3_type                pos;
   } div_stage_type;

endpackage

### hw/rtl/qpm_prod.sv
module qpm_prod
   import qpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  quat_req_type  up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output sum_stage_type dn_data
);

   logic           prod_valid_ff;
   logic           sum_valid_ff;
   logic           prod_ready;
   logic           sum_ready;
   prod_stage_type prod_in;
   prod_stage_type prod_ff;
   sum_stage_type  sum_in;
   sum_stage_type  sum_ff;

   function automatic num_type twice_sum(num_type a, num_type b);
      num_type s;
      s = a + b;
      return s <<< 1;
   endfunction

   assign sum_ready  = ~sum_valid_ff | dn_ready;
   assign prod_ready = ~prod_valid_ff | sum_ready;
   assign up_ready   = prod_ready;

   // ten products of the components
   always_comb begin
      prod_in.xx  = up_data.quat_x * up_data.quat_x;
      prod_in.yy  = up_data.quat_y * up_data.quat_y;
      prod_in.zz  = up_data.quat_z * up_data.quat_z;
      prod_in.ww  = up_data.quat_w * up_data.quat_w;
      prod_in.xy  = up_data.quat_x * up_data.quat_y;
      prod_in.xz  = up_data.quat_x * up_data.quat_z;
      prod_in.yz  = up_data.quat_y * up_data.quat_z;
      prod_in.xw  = up_data.quat_x * up_data.quat_w;
      prod_in.yw  = up_data.quat_y * up_data.quat_w;
      prod_in.zw  = up_data.quat_z * up_data.quat_w;
      prod_in.pos = '{x: up_data.pos_x, y: up_data.pos_y, z: up_data.pos_z};
   end

   // squared norm and numerators, off-diagonal ones doubled
   always_comb begin
      sum_in.norm = norm_type'(prod_ff.xx) + norm_type'(prod_ff.yy)
                  + norm_type'(prod_ff.zz) + norm_type'(prod_ff.ww);
      sum_in.num[E00] = num_type'(prod_ff.xx) + num_type'(prod_ff.ww)
                      - num_type'(prod_ff.yy) - num_type'(prod_ff.zz);
      sum_in.num[E11] = num_type'(prod_ff.yy) + num_type'(prod_ff.ww)
                      - num_type'(prod_ff.xx) - num_type'(prod_ff.zz);
      sum_in.num[E22] = num_type'(prod_ff.zz) + num_type'(prod_ff.ww)
                      - num_type'(prod_ff.xx) - num_type'(prod_ff.yy);
      sum_in.num[E01] = twice_sum(num_type'(prod_ff.xy), num_type'(prod_ff.zw));
      sum_in.num[E02] = twice_sum(num_type'(prod_ff.xz), -num_type'(prod_ff.yw));
      sum_in.num[E10] = twice_sum(num_type'(prod_ff.xy), -num_type'(prod_ff.zw));
      sum_in.num[E12] = twice_sum(num_type'(prod_ff.yz), num_type'(prod_ff.xw));
      sum_in.num[E20] = twice_sum(num_type'(prod_ff.xz), num_type'(prod_ff.yw));
      sum_in.num[E21] = twice_sum(num_type'(prod_ff.yz), -num_type'(prod_ff.xw));
      sum_in.pos = prod_ff.pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= up_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid & prod_ready) begin
         prod_ff <= prod_in;
      end
      if (prod_valid_ff & sum_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign dn_valid = sum_valid_ff;
   assign dn_data  = sum_ff;

endmodule

### hw/rtl/qpm_norm.sv
module qpm_norm
   import qpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  sum_stage_type up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output div_stage_type dn_data
);

   logic          mag_valid_ff;
   logic          dvd_valid_ff;
   logic          mag_ready;
   logic          dvd_ready;
   mag_stage_type mag_in;
   mag_stage_type mag_ff;
   div_stage_type dvd_in;
   div_stage_type dvd_ff;
   logic [NUM_ENT-1:0] mag_ok;

   assign dvd_ready = ~dvd_valid_ff | dn_ready;
   assign mag_ready = ~mag_valid_ff | dvd_ready;
   assign up_ready  = mag_ready;

   // sign and magnitude; every magnitude is bounded by the squared norm
   always_comb begin : mag_calc
      num_type abs_v;
      mag_in.norm = up_data.norm;
      mag_in.zero = (up_data.norm == '0);
      mag_in.pos  = up_data.pos;
      for (int i = 0; i < NUM_ENT; i++) begin
         mag_in.neg[i] = up_data.num[i][NUM_W-1];
         abs_v = up_data.num[i][NUM_W-1] ? -up_data.num[i] : up_data.num[i];
         mag_in.mag[i] = abs_v[NORM_W-1:0];
      end
   end

   // dividend mag * 2^frac + norm/2 gives round half away; high part seeds the remainder
   always_comb begin : dvd_calc
      logic [DVD_W-1:0] dvd;
      dvd_in.norm = mag_ff.norm;
      dvd_in.zero = mag_ff.zero;
      dvd_in.neg  = mag_ff.neg;
      dvd_in.pos  = mag_ff.pos;
      for (int i = 0; i < NUM_ENT; i++) begin
         dvd = (DVD_W'(mag_ff.mag[i]) << FRAC_BITS) + DVD_W'(mag_ff.norm >> 1);
         dvd_in.rem[i] = {1'b0, dvd[DVD_W-1:QUO_W]};
         dvd_in.acc[i] = dvd[QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
         dvd_valid_ff <= 1'b0;
      end else begin
         if (mag_ready) begin
            mag_valid_ff <= up_valid;
         end
         if (dvd_ready) begin
            dvd_valid_ff <= mag_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid & mag_ready) begin
         mag_ff <= mag_in;
      end
      if (mag_valid_ff & dvd_ready) begin
         dvd_ff <= dvd_in;
      end
   end

   assign dn_valid = dvd_valid_ff;
   assign dn_data  = dvd_ff;

   always_comb begin
      for (int i = 0; i < NUM_ENT; i++) begin
         mag_ok[i] = (mag_ff.mag[i] <= mag_ff.norm);
      end
   end

   a_mag_bounded: assert property (@(posedge clock) disable iff (reset)
      mag_valid_ff |-> &mag_ok)
      else $error("numerator magnitude above squared norm");

endmodule

### hw/rtl/qpm_div_step.sv
module qpm_div_step
   import qpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  div_stage_type up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output div_stage_type dn_data
);

   logic          valid_ff;
   div_stage_type step_in;
   div_stage_type step_ff;
   logic [NUM_ENT-1:0] rem_ok;

   assign up_ready = ~valid_ff | dn_ready;

   // one restoring division step per lane: dividend bit shifts out of acc, quotient bit in
   always_comb begin : step_calc
      logic [NORM_W:0] trial;
      logic [NORM_W:0] diff;
      logic            ge;
      step_in = up_data;
      for (int i = 0; i < NUM_ENT; i++) begin
         trial = {up_data.rem[i], up_data.acc[i][QUO_W-1]};
         diff  = trial - {1'b0, up_data.norm};
         ge    = (trial >= {1'b0, up_data.norm});
         step_in.rem[i] = ge ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
         step_in.acc[i] = {up_data.acc[i][QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid & up_ready) begin
         step_ff <= step_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = step_ff;

   always_comb begin
      for (int i = 0; i < NUM_ENT; i++) begin
         rem_ok[i] = (step_ff.rem[i] < step_ff.norm)
                   || (step_ff.zero && (step_ff.rem[i] == '0));
      end
   end

   a_rem_below_norm: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> &rem_ok)
      else $error("partial remainder not below divisor");

endmodule

### hw/rtl/quaternion_pose_to_matrix_unit.sv
// channel   dir  signals                          transaction
// req       in   req_valid req_ready req_payload   quaternion (Q1.14) and position
// rsp       out  rsp_valid rsp_ready rsp_payload   upper 3x4 pose matrix
//
// one transaction per cycle while rsp is not stalled
// the divider takes one quotient bit per stage, nine lanes side by side
// synchronous active-high reset empties every stage; payload registers are not reset
// a stall on rsp backs up stage by stage: empty stages still take data, nothing is lost
module quaternion_pose_to_matrix_unit
   import qpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  quat_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output pose_rsp_type rsp_payload
);

   // front end: products and sums, then magnitudes and dividend setup
   logic          sum_valid;
   logic          sum_ready;
   sum_stage_type sum_data;

   // division chain, index 0 is the seeded dividend, last index the finished quotient
   logic [QUO_W:0] div_valid;
   logic [QUO_W:0] div_ready;
   div_stage_type  div_data [0:QUO_W];

   // output register
   logic         rsp_valid_ff;
   pose_rsp_type rsp_ff;
   pose_rsp_type rsp_in;
   logic         out_ready;
   ent_type      ent [NUM_ENT];
   logic [NUM_ENT-1:0] quo_ok;

   qpm_prod u_prod (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_payload),
      .dn_valid (sum_valid),
      .dn_ready (sum_ready),
      .dn_data  (sum_data)
   );

   qpm_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sum_valid),
      .up_ready (sum_ready),
      .up_data  (sum_data),
      .dn_valid (div_valid[0]),
      .dn_ready (div_ready[0]),
      .dn_data  (div_data[0])
   );

   // one stage per quotient bit, msb first
   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      qpm_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[g]),
         .up_ready (div_ready[g]),
         .up_data  (div_data[g]),
         .dn_valid (div_valid[g+1]),
         .dn_ready (div_ready[g+1]),
         .dn_data  (div_data[g+1])
      );
   end

   assign out_ready         = ~rsp_valid_ff | rsp_ready;
   assign div_ready[QUO_W]  = out_ready;

   // saturate, apply sign, and force identity for a zero quaternion
   always_comb begin : ent_calc
      quo_type          q_sat;
      logic [RES_W-1:0] res;
      for (int i = 0; i < NUM_ENT; i++) begin
         q_sat = (div_data[QUO_W].acc[i] > Q_ONE) ? Q_ONE : div_data[QUO_W].acc[i];
         res   = div_data[QUO_W].neg[i] ? -RES_W'(q_sat) : RES_W'(q_sat);
         if (div_data[QUO_W].zero) begin
            // identity rotation: ones on the diagonal only
            res = (i == E00 || i == E11 || i == E22) ? RES_ONE : '0;
         end
         ent[i] = res[ENT_W-1:0];
      end
   end

   always_comb begin
      rsp_in.m00 = ent[E00];
      rsp_in.m01 = ent[E01];
      rsp_in.m02 = ent[E02];
      rsp_in.m03 = div_data[QUO_W].pos.x;
      rsp_in.m10 = ent[E10];
      rsp_in.m11 = ent[E11];
      rsp_in.m12 = ent[E12];
      rsp_in.m13 = div_data[QUO_W].pos.y;
      rsp_in.m20 = ent[E20];
      rsp_in.m21 = ent[E21];
      rsp_in.m22 = ent[E22];
      rsp_in.m23 = div_data[QUO_W].pos.z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (div_valid[QUO_W] & out_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // rounded quotient never goes past 1.0 unless the divisor was zero
   always_comb begin
      for (int i = 0; i < NUM_ENT; i++) begin
         quo_ok[i] = (div_data[QUO_W].acc[i] <= Q_ONE);
      end
   end

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline refused a transaction with an empty output");

   a_quo_in_range: assert property (@(posedge clock) disable iff (reset)
      (div_valid[QUO_W] && !div_data[QUO_W].zero) |-> &quo_ok)
      else $error("quotient above 1.0 for nonzero norm");

endmodule

### verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qpm_pkg::*;

   // full pipeline depth, every register stage from request to response
   localparam int PIPE_LATENCY = FRAC_BITS + 6;
   localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY;
   // watchdog limit, with a wide margin over the slowest legal run
   localparam int CYCLE_LIMIT  = 400000;
   // idle chance, in percent, for both the sender and the receiver
   localparam int IDLE_PCT     = 31;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   quat_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   pose_rsp_type rsp_payload;

   // matrices predicted for every accepted transaction, oldest first
   pose_rsp_type pending_poses[$];
   pose_rsp_type oldest_pose;
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   // when set, neither side idles: back-to-back traffic
   bit           no_idle        = 1'b0;
   // when set, only the sender streams without gaps
   bit           send_no_idle   = 1'b0;

   quaternion_pose_to_matrix_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // num * 2^shift / norm, rounded to nearest with ties away from zero,
   // clamped to +-1.0 and cut to the entry width
   function automatic ent_type rot_entry(input longint num, input int shift,
                                         input longint norm);
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] unity;
      unity = 64'd1 << FRAC_BITS;
      mag   = (num < 0) ? 64'(-num) : 64'(num);
      quo   = ((mag << shift) + (64'(norm) >> 1)) / 64'(norm);
      if (quo > unity) begin
         quo = unity;
      end
      if (num < 0) begin
         quo = -quo;
      end
      return ent_type'(quo[ENT_W-1:0]);
   endfunction

   // full pose matrix for one quaternion/position transaction
   function automatic pose_rsp_type predict_pose(input quat_req_type req);
      pose_rsp_type pose;
      longint       x, y, z, w;
      longint       xx, yy, zz, ww, xy, xz, yz, xw, yw, zw, norm;
      x    = longint'(req.quat_x);
      y    = longint'(req.quat_y);
      z    = longint'(req.quat_z);
      w    = longint'(req.quat_w);
      xx   = x * x;
      yy   = y * y;
      zz   = z * z;
      ww   = w * w;
      xy   = x * y;
      xz   = x * z;
      yz   = y * z;
      xw   = x * w;
      yw   = y * w;
      zw   = z * w;
      norm = xx + yy + zz + ww;
      pose = '0;
      if (norm == 0) begin
         // degenerate quaternion falls back to identity rotation
         pose.m00 = ent_type'(RES_ONE);
         pose.m11 = ent_type'(RES_ONE);
         pose.m22 = ent_type'(RES_ONE);
      end else begin
         // diagonal terms carry no factor 2, off-diagonal ones one extra bit
         pose.m00 = rot_entry(xx + ww - yy - zz, FRAC_BITS, norm);
         pose.m01 = rot_entry(xy + zw, FRAC_BITS + 1, norm);
         pose.m02 = rot_entry(xz - yw, FRAC_BITS + 1, norm);
         pose.m10 = rot_entry(xy - zw, FRAC_BITS + 1, norm);
         pose.m11 = rot_entry(yy + ww - xx - zz, FRAC_BITS, norm);
         pose.m12 = rot_entry(yz + xw, FRAC_BITS + 1, norm);
         pose.m20 = rot_entry(xz + yw, FRAC_BITS + 1, norm);
         pose.m21 = rot_entry(yz - xw, FRAC_BITS + 1, norm);
         pose.m22 = rot_entry(zz + ww - xx - yy, FRAC_BITS, norm);
      end
      // translation column passes straight through
      pose.m03 = req.pos_x;
      pose.m13 = req.pos_y;
      pose.m23 = req.pos_z;
      return pose;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic check_entry(input string label, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   task automatic check_pose(input pose_rsp_type want, input pose_rsp_type got);
      check_entry("m00", want.m00, got.m00);
      check_entry("m01", want.m01, got.m01);
      check_entry("m02", want.m02, got.m02);
      check_entry("m03", want.m03, got.m03);
      check_entry("m10", want.m10, got.m10);
      check_entry("m11", want.m11, got.m11);
      check_entry("m12", want.m12, got.m12);
      check_entry("m13", want.m13, got.m13);
      check_entry("m20", want.m20, got.m20);
      check_entry("m21", want.m21, got.m21);
      check_entry("m22", want.m22, got.m22);
      check_entry("m23", want.m23, got.m23);
   endtask

   // both handshakes are watched at the rising edge; the result is checked
   // before the new transaction is queued, pipeline latency keeps them apart
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_poses.size() == 0) begin
               mismatch_count++;
               $display("%0t: result transaction with nothing expected, expected none, got %h",
                        $time, rsp_payload);
            end else begin
               oldest_pose = pending_poses.pop_front();
               check_pose(oldest_pose, rsp_payload);
            end
         end
         if (req_valid && req_ready) begin
            pending_poses.push_back(predict_pose(req_payload));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** quaternion_pose_to_matrix_unit: FAILED **");
         $finish;
      end
   end

   // receiver: random back-pressure unless in a no-idle stretch
   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   // entered and left just after a falling edge; valid stays up between
   // back-to-back transactions
   task automatic send_pose(input quat_req_type item);
      while (!no_idle && !send_no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   function automatic quat_req_type make_req(input int x, input int y, input int z,
                                             input int w, input logic [31:0] px,
                                             input logic [31:0] py, input logic [31:0] pz);
      quat_req_type req;
      req.quat_x = comp_type'(x);
      req.quat_y = comp_type'(y);
      req.quat_z = comp_type'(z);
      req.quat_w = comp_type'(w);
      req.pos_x  = pos_type'(px);
      req.pos_y  = pos_type'(py);
      req.pos_z  = pos_type'(pz);
      return req;
   endfunction

   // component near a range boundary or a unit value, zero, or fully random
   function automatic comp_type corner_comp();
      unique case ($urandom_range(0, 7))
         0: return comp_type'(-32768);
         1: return comp_type'(32767);
         2: return comp_type'(16384);
         3: return comp_type'(-16384);
         4: return comp_type'(1);
         5: return comp_type'(-1);
         6: return comp_type'(0);
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic quat_req_type random_req();
      quat_req_type req;
      int           mode;
      int           axis;
      mode       = $urandom_range(0, 99);
      req.pos_x  = pos_type'($urandom);
      req.pos_y  = pos_type'($urandom);
      req.pos_z  = pos_type'($urandom);
      if (mode < 55) begin
         // full-range components
         req.quat_x = comp_type'($urandom);
         req.quat_y = comp_type'($urandom);
         req.quat_z = comp_type'($urandom);
         req.quat_w = comp_type'($urandom);
      end else if (mode < 75) begin
         // tiny norms: coarse ratios and the odd all-zero quaternion
         req.quat_x = comp_type'(int'($urandom_range(0, 8)) - 4);
         req.quat_y = comp_type'(int'($urandom_range(0, 8)) - 4);
         req.quat_z = comp_type'(int'($urandom_range(0, 8)) - 4);
         req.quat_w = comp_type'(int'($urandom_range(0, 8)) - 4);
      end else if (mode < 92) begin
         req.quat_x = corner_comp();
         req.quat_y = corner_comp();
         req.quat_z = corner_comp();
         req.quat_w = corner_comp();
      end else if (mode < 96) begin
         // zero quaternion, identity expected
         req.quat_x = '0;
         req.quat_y = '0;
         req.quat_z = '0;
         req.quat_w = '0;
      end else begin
         // single axis, exact +-1.0 entries
         req.quat_x = '0;
         req.quat_y = '0;
         req.quat_z = '0;
         req.quat_w = '0;
         axis       = $urandom_range(0, 3);
         unique case (axis)
            0: req.quat_x = comp_type'($urandom);
            1: req.quat_y = comp_type'($urandom);
            2: req.quat_z = comp_type'($urandom);
            default: req.quat_w = comp_type'($urandom);
         endcase
      end
      return req;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // identity, axis turns, zero quaternion, component and position extremes
   task automatic test_directed_corners();
      send_pose(make_req(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00000000));
      send_pose(make_req(0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'hffffffff));
      send_pose(make_req(0, 0, 0, 16384, 32'h00000001, 32'hffffffff, 32'h00000000));
      send_pose(make_req(0, 0, 0, -16384, 32'h55555555, 32'haaaaaaaa, 32'h55555555));
      send_pose(make_req(16384, 0, 0, 0, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
      send_pose(make_req(0, 16384, 0, 0, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f));
      send_pose(make_req(0, 0, 16384, 0, 32'hf0f0f0f0, 32'h00ff00ff, 32'hff00ff00));
      send_pose(make_req(-32768, -32768, -32768, -32768, 32'hffffffff, 32'hffffffff,
                         32'hffffffff));
      send_pose(make_req(32767, 32767, 32767, 32767, 32'h7fffffff, 32'h7fffffff,
                         32'h7fffffff));
      send_pose(make_req(-32768, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000));
      send_pose(make_req(32767, -32768, 32767, -32768, 32'h0, 32'h1, 32'h2));
      send_pose(make_req(32767, 0, 0, -32768, 32'h3, 32'h4, 32'h5));
      send_pose(make_req(1, 0, 0, 0, 32'h6, 32'h7, 32'h8));
      send_pose(make_req(0, 0, 0, 1, 32'h9, 32'ha, 32'hb));
      send_pose(make_req(0, 0, -1, 0, 32'hc, 32'hd, 32'he));
      send_pose(make_req(1, 1, 1, 1, 32'h10, 32'h20, 32'h40));
      send_pose(make_req(1, -1, 0, 0, 32'h80, 32'h100, 32'h200));
      send_pose(make_req(-1, 0, 0, 1, 32'h400, 32'h800, 32'h1000));
      send_pose(make_req(11585, 0, 0, 11585, 32'h00010000, 32'hffff0000, 32'h0));
      send_pose(make_req(0, -11585, 0, 11585, 32'h0, 32'h00010000, 32'hffff0000));
      send_pose(make_req(3, -7, 5, -2, 32'hdeadbeef, 32'h01234567, 32'h89abcdef));
      send_pose(make_req(-16384, 16384, -16384, 16384, 32'h0, 32'h0, 32'h0));
   endtask

   // random quaternions under random idling on both sides
   task automatic test_random_poses(input int count);
      for (int i = 0; i < count; i++) begin
         send_pose(random_req());
      end
   endtask

   // full-rate stream with the receiver always ready
   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      for (int i = 0; i < count; i++) begin
         send_pose(random_req());
      end
      no_idle = 1'b0;
   endtask

   // receiver stalls alone while the sender streams without gaps
   task automatic test_output_stall(input int count);
      send_no_idle = 1'b1;
      for (int i = 0; i < count; i++) begin
         send_pose(random_req());
      end
      send_no_idle = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_corners();
      test_random_poses(1000);
      test_back_to_back(300);
      test_output_stall(200);

      req_valid <= 1'b0;
      while (pending_poses.size() != 0) begin
         @(posedge clock);
      end
      // anything that shows up now is an extra result
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** quaternion_pose_to_matrix_unit: PASSED **");
      end else begin
         $display("** quaternion_pose_to_matrix_unit: FAILED **");
      end
      $finish;
   end

endmodule
